// ===== sv/chrg_pkg.sv =====
package chrg_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int STEP_W = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] GOLDEN64 = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] FMIX_M1  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [WORD_W-1:0] FMIX_M2  = 64'hc4ce_b9fe_1a85_ec53;

    localparam int FMIX_SHIFT = 33;

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_MOD  = 7'd95;
    localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd32;

    localparam int WEIGHT_W = 32;
    localparam int FRAC24_W = 24;
    localparam int FRAC53_W = 53;

endpackage

// ===== sv/chrg_mul64lo.sv =====
module chrg_mul64lo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chrg_pkg::WORD_W-1:0]  i_a,
    input  logic [chrg_pkg::WORD_W-1:0]  i_b,
    output logic                         o_done,
    output logic [chrg_pkg::WORD_W-1:0]  o_prod
);

    localparam int HW = chrg_pkg::HALF_W;
    localparam int WW = chrg_pkg::WORD_W;

    logic [WW-1:0] r_a;
    logic [WW-1:0] r_b;
    logic [WW-1:0] r_pp;
    logic [WW-1:0] r_acc;
    logic [1:0]    r_step;
    logic          r_busy;
    logic          r_done;

    logic [HW-1:0] op_x;
    logic [HW-1:0] op_y;
    logic [WW-1:0] n_pp;

    // low 64 bits only: lo*lo + (lo*hi + hi*lo) << 32, one partial product a cycle
    always_comb begin
        case (r_step)
            2'd0: begin
                op_x = r_a[HW-1:0];
                op_y = r_b[HW-1:0];
            end
            2'd1: begin
                op_x = r_a[HW-1:0];
                op_y = r_b[WW-1:HW];
            end
            2'd2: begin
                op_x = r_a[WW-1:HW];
                op_y = r_b[HW-1:0];
            end
            default: begin
                op_x = '0;
                op_y = '0;
            end
        endcase
        n_pp = WW'(op_x) * WW'(op_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            r_pp <= n_pp;
            case (r_step)
                2'd1:    r_acc <= r_pp;
                2'd2:    r_acc <= r_acc + {r_pp[HW-1:0], {HW{1'b0}}};
                2'd3:    r_acc <= r_acc + {r_pp[HW-1:0], {HW{1'b0}}};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/counter_hash_random_generator.sv =====
// Order: a draw runs three passes through the shared 32x32 multiplier and then a 64-step
//   remainder loop before it gives its result; a weighted trial that needs no draw gives
//   its result on the next cycle.
// Flow: one item at a time; a new input is taken only once the last result has been
//   taken, so a result that waits on i_m_tready holds the input off for as long as it waits.
// Reset: synchronous, active low; clears seed, counter, salt and all control, no sweep.
module counter_hash_random_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // [31:0] weight, [63:32] total
    input  logic         i_s_tuser,   // [0] kind
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [63:0] raw_value, [87:64] frac24, [140:88] frac53, [164:141] signed_unit,
    // [171:165] char_code, [172] hit, [175:173] zero
    output logic [175:0] o_m_tdata,
    output logic         o_m_tuser,   // [0] drew
    // configuration
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    output logic [63:0]  o_prdata,
    output logic         o_pready
);

    localparam int WW = chrg_pkg::WORD_W;
    localparam int KW = chrg_pkg::WEIGHT_W;
    localparam int CW = chrg_pkg::CHAR_W;
    localparam int SW = chrg_pkg::STEP_W;

    // 2^7 = 33 (mod 95) and 33 = 2^5 + 1
    localparam int FOLD_W  = 7;
    localparam int FOLD_SH = 5;

    localparam logic REG_SEED = 1'b0;
    localparam logic REG_SALT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MIX1,
        S_MIX2,
        S_REM,
        S_OUT
    } t_state;

    t_state        r_state;
    logic [WW-1:0] r_seed_init;
    logic [WW-1:0] r_salt;
    logic [WW-1:0] r_seed;
    logic [WW-1:0] r_count;
    logic          r_kind;
    logic [KW-1:0] r_weight;
    logic [KW-1:0] r_total;
    logic [WW-1:0] r_div_a;
    logic [WW-1:0] r_div_b;
    logic [KW-1:0] r_rem_a;
    logic [SW-1:0] r_steps;
    logic          r_out_valid;
    logic          r_out_drew;
    logic [WW-1:0] r_out_word;
    logic [CW-1:0] r_out_char;
    logic          r_out_hit;

    logic          s_accept;
    logic          in_kind;
    logic [KW-1:0] in_weight;
    logic [KW-1:0] in_total;
    logic          no_draw;
    logic          cfg_wr;

    logic          mul_start;
    logic [WW-1:0] mul_a;
    logic [WW-1:0] mul_b;
    logic          mul_done;
    logic [WW-1:0] mul_prod;
    logic [WW-1:0] mixed;
    logic [WW-1:0] fold;
    logic [WW-1:0] mag;

    logic [KW:0]   rem_ta;
    logic [KW-1:0] n_rem_a;
    logic [WW-1:0] n_div_b;
    logic [CW-1:0] char_low;
    logic [CW-1:0] n_char_rem;

    logic [23:0]   su_field;

    assign s_accept  = i_s_tvalid & o_s_tready;
    assign in_kind   = i_s_tuser;
    assign in_weight = i_s_tdata[KW-1:0];
    assign in_total  = i_s_tdata[2*KW-1:KW];
    assign no_draw   = in_kind && ((in_total == '0) || (in_weight >= in_total)
                                   || (in_weight == '0));
    assign cfg_wr    = i_psel & i_penable & i_pwrite & o_pready;

    assign mixed = r_seed ^ r_salt ^ mul_prod;
    assign fold  = mul_prod ^ (mul_prod >> chrg_pkg::FMIX_SHIFT);
    // magnitude of the word as signed; the most negative word maps to 2^63 unsigned
    assign mag   = fold[WW-1] ? (~fold + WW'(1)) : fold;

    always_comb begin
        mul_start = 1'b0;
        mul_a     = fold;
        mul_b     = chrg_pkg::FMIX_M2;
        unique case (r_state)
            S_IDLE: begin
                mul_start = s_accept && !no_draw;
                mul_a     = r_count;
                mul_b     = chrg_pkg::GOLDEN64;
            end
            S_MUL0: begin
                mul_start = mul_done;
                mul_a     = mixed ^ (mixed >> chrg_pkg::FMIX_SHIFT);
                mul_b     = chrg_pkg::FMIX_M1;
            end
            S_MIX1: begin
                mul_start = mul_done;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    chrg_mul64lo u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // one restoring remainder step per cycle for mod total; beside it, fold the
    // magnitude by 2^7 = 33 (mod 95) until it drops below 128, then one compare and subtract
    always_comb begin
        rem_ta     = {r_rem_a, r_div_a[WW-1]};
        n_rem_a    = (rem_ta >= {1'b0, r_total}) ? KW'(rem_ta - {1'b0, r_total}) : rem_ta[KW-1:0];
        n_div_b    = WW'({r_div_b[WW-1:FOLD_W], {FOLD_SH{1'b0}}})
                   + WW'(r_div_b[WW-1:FOLD_W]) + WW'(r_div_b[FOLD_W-1:0]);
        char_low   = n_div_b[CW-1:0];
        n_char_rem = (char_low >= chrg_pkg::CHAR_MOD) ? (char_low - chrg_pkg::CHAR_MOD)
                                                      : char_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed_init <= '0;
            r_salt      <= '0;
            r_seed      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (i_paddr[3])
                    REG_SEED: begin
                        r_seed_init <= i_pwdata;
                        r_seed      <= i_pwdata;
                        r_count     <= '0;
                    end
                    REG_SALT: r_salt <= i_pwdata;
                    default:  r_salt <= r_salt;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_kind   <= in_kind;
                        r_weight <= in_weight;
                        r_total  <= in_total;
                        if (no_draw) begin
                            r_out_valid <= 1'b1;
                            r_out_drew  <= 1'b0;
                            r_out_word  <= '0;
                            r_out_char  <= '0;
                            r_out_hit   <= (in_total != '0) && (in_weight >= in_total);
                            r_state     <= S_OUT;
                        end else begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MUL0: begin
                    if (mul_done) r_state <= S_MIX1;
                end
                S_MIX1: begin
                    if (mul_done) r_state <= S_MIX2;
                end
                S_MIX2: begin
                    if (mul_done) begin
                        r_out_word <= fold;
                        r_seed     <= fold;
                        r_count    <= r_count + WW'(1);
                        r_div_a    <= {1'b0, fold[WW-2:0]};
                        r_div_b    <= mag;
                        r_rem_a    <= '0;
                        r_steps    <= '0;
                        r_state    <= S_REM;
                    end
                end
                S_REM: begin
                    r_div_a <= {r_div_a[WW-2:0], 1'b0};
                    r_div_b <= n_div_b;
                    r_rem_a <= n_rem_a;
                    r_steps <= r_steps + SW'(1);
                    if (r_steps == SW'(WW - 1)) begin
                        r_out_valid <= 1'b1;
                        r_out_drew  <= 1'b1;
                        r_out_char  <= chrg_pkg::CHAR_BASE + n_char_rem;
                        r_out_hit   <= r_kind && (n_rem_a < r_weight);
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign su_field = r_out_drew ? {~r_out_word[23], r_out_word[22:0]} : '0;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_drew;
    assign o_m_tdata  = {3'b000, r_out_hit, r_out_char, su_field,
                         r_out_word[chrg_pkg::FRAC53_W-1:0],
                         r_out_word[chrg_pkg::FRAC24_W-1:0], r_out_word};

    assign o_prdata = (i_paddr[3] == REG_SALT) ? r_salt : r_seed_init;
    assign o_pready = 1'b1;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input taken while a result is pending");

    a_no_draw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[171:0] == '0))
        else $error("no-draw result carries word bits");

    a_plain_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_kind) |-> !o_m_tdata[172])
        else $error("plain draw reports a hit");

    a_mul_in_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL0 || r_state == S_MIX1 || r_state == S_MIX2))
        else $error("multiplier finished outside the mixing sequence");

endmodule

// ===== tb/chrg_tb_pkg.sv =====
package chrg_tb_pkg;

    // byte addresses of the 64-bit configuration registers
    localparam logic [3:0] SEED_INIT_ADDR     = 4'h0;
    localparam logic [3:0] INSTANCE_SALT_ADDR = 4'h8;

    typedef enum logic {
        KIND_DRAW  = 1'b0,
        KIND_TRIAL = 1'b1
    } t_draw_kind;

endpackage

// ===== tb/chrg_checker.sv =====
module chrg_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_s_tdata,   // [31:0] weight, [63:32] total
    input  logic         i_s_tuser,   // [0] kind
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // [63:0] raw_value, [87:64] frac24, [140:88] frac53, [164:141] signed_unit,
    // [171:165] char_code, [172] hit, [175:173] zero
    input  logic [175:0] i_m_tdata,
    input  logic         i_m_tuser,   // [0] drew
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_errors,
    output int           o_pending
);

    // laid out like the master tdata bus, highest field first
    typedef struct packed {
        logic [2:0]  pad;
        logic        hit;
        logic [6:0]  char_code;
        logic [23:0] signed_unit;
        logic [52:0] frac53;
        logic [23:0] frac24;
        logic [63:0] raw_value;
    } t_draw_fields;

    typedef struct {
        logic         drew;
        t_draw_fields fields;
    } t_draw_result;

    t_draw_result expected_draws[$];
    logic [63:0]  seed_state;
    logic [63:0]  salt_value;
    logic [63:0]  draw_index;
    int           err_count = 0;

    assign o_errors = err_count;

    function automatic logic [63:0] fmix(input logic [63:0] k);
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        k = k * chrg_pkg::FMIX_M1;
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        k = k * chrg_pkg::FMIX_M2;
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        return k;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_draw_result           exp_r;
        t_draw_fields           got;
        chrg_tb_pkg::t_draw_kind kind;
        logic [31:0]            weight;
        logic [31:0]            total;
        logic [63:0]            word;
        logic [63:0]            mag;
        logic                   needs_draw;

        if (!i_rst_n) begin
            seed_state = '0;
            salt_value = '0;
            draw_index = '0;
            expected_draws.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == chrg_tb_pkg::SEED_INIT_ADDR) begin
                    seed_state = i_pwdata;
                    draw_index = '0;
                end else if (i_paddr == chrg_tb_pkg::INSTANCE_SALT_ADDR) begin
                    salt_value = i_pwdata;
                end
            end

            // retire before predicting, so a stray result never matches a fresh item
            if (i_m_tvalid && i_m_tready) begin
                if (expected_draws.size() == 0) begin
                    $error("result transaction with no pending item: tdata 0x%0h",
                           i_m_tdata);
                    err_count++;
                end else begin
                    exp_r = expected_draws.pop_front();
                    got   = i_m_tdata;
                    check_field("drew", exp_r.drew, i_m_tuser);
                    check_field("raw_value", exp_r.fields.raw_value, got.raw_value);
                    check_field("frac24", exp_r.fields.frac24, got.frac24);
                    check_field("frac53", exp_r.fields.frac53, got.frac53);
                    check_field("signed_unit", exp_r.fields.signed_unit, got.signed_unit);
                    check_field("char_code", exp_r.fields.char_code, got.char_code);
                    check_field("hit", exp_r.fields.hit, got.hit);
                    check_field("pad", exp_r.fields.pad, got.pad);
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                kind   = chrg_tb_pkg::t_draw_kind'(i_s_tuser);
                weight = i_s_tdata[31:0];
                total  = i_s_tdata[63:32];
                exp_r  = '{drew: 1'b0, fields: '0};
                needs_draw = (kind == chrg_tb_pkg::KIND_DRAW) ||
                             (total != 0 && weight < total && weight != 0);
                if (kind == chrg_tb_pkg::KIND_TRIAL && total != 0 && weight >= total)
                    exp_r.fields.hit = 1'b1;
                if (needs_draw) begin
                    word       = fmix(seed_state ^ salt_value
                                      ^ (draw_index * chrg_pkg::GOLDEN64));
                    seed_state = word;
                    draw_index = draw_index + 64'd1;
                    // magnitude of the most negative word wraps back to 2^63
                    mag = word[63] ? (~word + 64'd1) : word;
                    exp_r.drew                = 1'b1;
                    exp_r.fields.raw_value    = word;
                    exp_r.fields.frac24       = word[23:0];
                    exp_r.fields.frac53       = word[52:0];
                    exp_r.fields.signed_unit  = word[23:0] ^ 24'h80_0000;
                    exp_r.fields.char_code    = chrg_pkg::CHAR_BASE
                                              + 7'(mag % 64'(chrg_pkg::CHAR_MOD));
                    if (kind == chrg_tb_pkg::KIND_TRIAL)
                        exp_r.fields.hit = ({1'b0, word[62:0]} % 64'(total)) < 64'(weight);
                end
                expected_draws.push_back(exp_r);
            end
        end
        o_pending <= expected_draws.size();
    end

endmodule

// ===== tb/counter_hash_random_generator_test.sv =====
module counter_hash_random_generator_test;

    localparam int MAX_GAP      = 8;
    localparam int HOLD_CYCLES  = 1500;
    localparam int HOLD_AT      = 100;
    localparam int PHASE_ITEMS  = 300;
    localparam int STEADY_ITEMS = 60;
    localparam int TAIL_CYCLES  = 100;

    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [63:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tready  = 1'b0;
    logic         psel      = 1'b0;
    logic         penable   = 1'b0;
    logic         pwrite    = 1'b0;
    logic [3:0]   paddr     = '0;
    logic [63:0]  pwdata    = '0;
    logic         steady    = 1'b0;

    logic         s_tready;
    logic         m_tvalid;
    logic [175:0] m_tdata;
    logic         m_tuser;
    logic [63:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    int           results_taken = 0;

    counter_hash_random_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    chrg_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("FAIL counter_hash_random_generator");
        $finish;
    end

    // multiplicative inverse mod 2^64 by Newton iteration
    function automatic logic [63:0] mul_inverse(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        repeat (6) x = x * (64'd2 - a * x);
        return x;
    endfunction

    task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input chrg_tb_pkg::t_draw_kind kind, input logic [31:0] weight,
                             input logic [31:0] total);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {total, weight};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // hold the input until every pending result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [63:0] seed, input logic [63:0] salt);
        drain();
        reg_write(chrg_tb_pkg::INSTANCE_SALT_ADDR, salt);
        reg_write(chrg_tb_pkg::SEED_INIT_ADDR, seed);
    endtask

    task automatic random_item();
        logic [31:0] weight;
        logic [31:0] total;
        int          pick;
        weight = $urandom;
        total  = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            send_item(chrg_tb_pkg::KIND_DRAW, weight, total);
        end else begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    total = '0;
                end
                1: begin
                    weight = '0;
                    if (total == 0) total = 32'd1;
                end
                2: begin
                    if (total == 0) total = 32'd1;
                    weight = $urandom_range(total, 32'hFFFF_FFFF);
                end
                default: begin
                    // mostly real trials, with small and full-range divisors
                    if (pick < 6) total = $urandom_range(2, 20);
                    if (total < 2) total = 32'd2;
                    weight = $urandom_range(1, total - 1);
                end
            endcase
            send_item(chrg_tb_pkg::KIND_TRIAL, weight, total);
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            results_taken++;
        end
    end

    initial begin
        logic [63:0] k;
        logic [63:0] seed;
        logic [63:0] salt;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: zero seed and zero salt
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h0, 32'h0);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'h0, 32'h0);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'hFFFF_FFFF, 32'h0);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd5, 32'd5);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'hFFFF_FFFF, 32'd1);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'h0, 32'hFFFF_FFFF);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd1, 32'd2);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd1, 32'hFFFF_FFFF);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h0, 32'h0);

        configure('1, '1);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h0, 32'h0);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd3, 32'd7);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h5555_5555, 32'hAAAA_AAAA);

        // seed whose first draw is the most negative word
        k = 64'h8000_0000_0000_0000;
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        k = k * mul_inverse(chrg_pkg::FMIX_M2);
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        k = k * mul_inverse(chrg_pkg::FMIX_M1);
        k = k ^ (k >> chrg_pkg::FMIX_SHIFT);
        configure(k, '0);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h0, 32'h0);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd2, 32'd3);
        send_item(chrg_tb_pkg::KIND_DRAW, 32'h0, 32'h0);
        configure(k, '0);
        send_item(chrg_tb_pkg::KIND_TRIAL, 32'd1, 32'd3);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin seed = {$urandom, $urandom}; salt = '0; end
                1:       begin seed = '0; salt = {$urandom, $urandom}; end
                2:       begin seed = {$urandom, $urandom}; salt = {$urandom, $urandom}; end
                default: begin seed = '1; salt = '0; end
            endcase
            configure(seed, salt);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                steady = (i < STEADY_ITEMS);
                random_item();
            end
        end
        steady = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS counter_hash_random_generator");
        end else begin
            $display("FAIL counter_hash_random_generator");
        end
        $finish;
    end

endmodule
